// ----- rtl/json_tok_pkg.sv -----
// ----------------------------------------------------------------------------
// json_tok_pkg
// Shared types, codes and small tables for the JSON byte tokenizer.
// ----------------------------------------------------------------------------
package json_tok_pkg;

    // Event codes carried on the event channel.
    typedef enum logic [3:0] {
        EV_END      = 4'd0,
        EV_ERROR    = 4'd1,
        EV_LBRACE   = 4'd2,
        EV_RBRACE   = 4'd3,
        EV_LBRACKET = 4'd4,
        EV_RBRACKET = 4'd5,
        EV_COLON    = 4'd6,
        EV_COMMA    = 4'd7,
        EV_STRBYTE  = 4'd8,
        EV_STREND   = 4'd9,
        EV_NUMBYTE  = 4'd10,
        EV_NUMEND   = 4'd11,
        EV_TRUE     = 4'd12,
        EV_FALSE    = 4'd13,
        EV_NULL     = 4'd14
    } ev_kind_t;

    // Lexer modes.
    typedef enum logic [4:0] {
        MODE_IDLE   = 5'd0,
        MODE_STR    = 5'd1,
        MODE_ESC    = 5'd2,
        MODE_HEX    = 5'd3,
        MODE_LIT    = 5'd4,
        MODE_NSIGN  = 5'd5,
        MODE_NINT   = 5'd6,
        MODE_NFRAC0 = 5'd7,
        MODE_NFRAC  = 5'd8,
        MODE_NEXP0  = 5'd9,
        MODE_NEXPS  = 5'd10,
        MODE_NEXP   = 5'd11,
        MODE_ERR    = 5'd12
    } lexer_mode_t;

    // Literal selector codes.
    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    localparam int unsigned MAX_EVENTS = 3;

    localparam logic [7:0]  CTRL_LIMIT  = 8'h20;
    localparam logic [15:0] UTF8_MAX1   = 16'h007F;
    localparam logic [15:0] UTF8_MAX2   = 16'h07FF;
    localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
    localparam logic [7:0]  UTF8_CONT   = 8'h80;
    localparam logic [5:0]  UTF8_MASK   = 6'h3F;

    // One token event.
    typedef struct packed {
        ev_kind_t   kind;
        logic [7:0] ev_byte;
    } event_t;

    // The run of events that one input byte causes.
    typedef struct packed {
        logic [1:0]                    count;
        event_t [MAX_EVENTS-1:0]       ev;
    } run_t;

    // Number of tail characters of a literal after its first letter.
    function automatic logic [2:0] lit_len(input logic [1:0] sel);
        return (sel == LIT_FALSE) ? 3'd4 : 3'd3;
    endfunction

    // Tail characters: "rue", "alse", "ull".
    function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (sel)
            LIT_TRUE:
            begin
                case (pos)
                    3'd0:    c = "r";
                    3'd1:    c = "u";
                    3'd2:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            LIT_FALSE:
            begin
                case (pos)
                    3'd0:    c = "a";
                    3'd1:    c = "l";
                    3'd2:    c = "s";
                    3'd3:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            default:
            begin
                case (pos)
                    3'd0:    c = "u";
                    3'd1:    c = "l";
                    3'd2:    c = "l";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/json_tok_in_if.sv -----
// ----------------------------------------------------------------------------
// json_tok_in_if
// Byte channel into the tokenizer: valid, ready and one text byte.
// ----------------------------------------------------------------------------
interface json_tok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- rtl/json_tok_out_if.sv -----
// ----------------------------------------------------------------------------
// json_tok_out_if
// Event channel out of the tokenizer: valid, ready and one token event.
// ----------------------------------------------------------------------------
interface json_tok_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_kind;
    logic [7:0] event_byte;
    logic       last_of_run;

    modport source (output valid, output event_kind, output event_byte,
                    output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input event_byte,
                    input last_of_run, output ready);
endinterface

// ----- rtl/json_byte_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// json_byte_tokenizer_core
// Streaming JSON lexer: one text byte in, a short run of token events out.
// ----------------------------------------------------------------------------
// The text channel takes one byte per beat; byte zero ends a document and
// always yields an end event, after which the lexer is ready for the next one.
// The event channel gives one token event per beat. Every byte yields zero to
// three events, and last_of_run marks the final event of each byte's run.
// An accepted byte waits in the input register, is lexed on its way into the
// result register, and its first event is shown from the result register. A
// byte that gives no event leaves nothing on the event channel, only a lexer
// state update. Throughput is one byte per cycle while each byte gives at
// most one event and the receiver is ready; a byte that gives n events holds
// the result register until all n are taken, so the rate is set by the single
// result register and its one event per cycle.
// When the receiver stalls, the current event holds, an empty input register
// still takes one more byte, and then the text channel drops ready until the
// run has drained. Reset clears both registers' valid state and puts the lexer
// back between tokens with the escape and literal counters at zero.
// ----------------------------------------------------------------------------
module json_byte_tokenizer_core
    import json_tok_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    json_tok_in_if.sink    text,
    json_tok_out_if.source tokens
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       free;
    logic       step;
    logic       in_fire;
    run_t       run;

    // A byte moves into the lexer when the result register can take its run.
    assign step       = in_valid_reg && free;
    assign text.ready = !in_valid_reg || step;
    assign in_fire    = text.valid && text.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_fire)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            in_byte_reg <= text.in_byte;
    end

    json_tok_lexer u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_byte (in_byte_reg),
        .run     (run)
    );

    json_tok_run_buf u_run_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (step),
        .run    (run),
        .free   (free),
        .events (tokens)
    );

endmodule

// ----- rtl/json_tok_lexer.sv -----
// ----------------------------------------------------------------------------
// json_tok_lexer
// Lexer state registers and the one-byte step that yields a run of events.
// ----------------------------------------------------------------------------
module json_tok_lexer
    import json_tok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] in_byte,
    output run_t       run
);

    typedef struct packed {
        logic        emit;
        ev_kind_t    kind;
        logic [7:0]  ev_byte;
        lexer_mode_t mode;
        logic        set_lit;
        logic [1:0]  sel;
    } idle_res_t;

    lexer_mode_t mode_reg, mode_next;
    logic [15:0] hex_acc_reg, hex_acc_next;
    logic [2:0]  hex_cnt_reg, hex_cnt_next;
    logic [1:0]  lit_sel_reg, lit_sel_next;
    logic [2:0]  lit_pos_reg, lit_pos_next;

    logic        do_fail;
    logic        do_idle;
    logic        do_numend;
    logic [4:0]  hex_val;
    logic [2:0]  pos_inc;
    idle_res_t   ir;

    function automatic run_t push(input run_t r, input ev_kind_t k, input logic [7:0] b);
        run_t q;
        q = r;
        if (r.count != 2'd3)
        begin
            q.ev[r.count] = '{kind: k, ev_byte: b};
            q.count       = r.count + 2'd1;
        end
        return q;
    endfunction

    // Bit 4 flags a byte that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        case (b) inside
            ["0":"9"]: v = {1'b0, 4'(b - 8'h30)};
            ["a":"f"]: v = {1'b0, 4'(b - 8'h57)};
            ["A":"F"]: v = {1'b0, 4'(b - 8'h37)};
            default:   v = 5'h10;
        endcase
        return v;
    endfunction

    function automatic idle_res_t idle_step(input logic [7:0] b);
        idle_res_t r;
        r = '{emit: 1'b0, kind: EV_END, ev_byte: 8'h00, mode: MODE_IDLE,
              set_lit: 1'b0, sel: LIT_TRUE};
        if (b == 8'h00)
        begin
            r.emit = 1'b1;
        end
        else if (b > CTRL_LIMIT)
        begin
            case (b) inside
                "{":       begin r.emit = 1'b1; r.kind = EV_LBRACE;   end
                "}":       begin r.emit = 1'b1; r.kind = EV_RBRACE;   end
                "[":       begin r.emit = 1'b1; r.kind = EV_LBRACKET; end
                "]":       begin r.emit = 1'b1; r.kind = EV_RBRACKET; end
                ":":       begin r.emit = 1'b1; r.kind = EV_COLON;    end
                ",":       begin r.emit = 1'b1; r.kind = EV_COMMA;    end
                "\"":      r.mode = MODE_STR;
                "t":       begin r.set_lit = 1'b1; r.sel = LIT_TRUE;  r.mode = MODE_LIT; end
                "f":       begin r.set_lit = 1'b1; r.sel = LIT_FALSE; r.mode = MODE_LIT; end
                "n":       begin r.set_lit = 1'b1; r.sel = LIT_NULL;  r.mode = MODE_LIT; end
                "-":
                begin
                    r.emit = 1'b1; r.kind = EV_NUMBYTE; r.ev_byte = b; r.mode = MODE_NSIGN;
                end
                ["0":"9"]:
                begin
                    r.emit = 1'b1; r.kind = EV_NUMBYTE; r.ev_byte = b; r.mode = MODE_NINT;
                end
                default:
                begin
                    r.emit = 1'b1; r.kind = EV_ERROR; r.mode = MODE_ERR;
                end
            endcase
        end
        return r;
    endfunction

    always_comb
    begin
        run          = '0;
        mode_next    = mode_reg;
        hex_acc_next = hex_acc_reg;
        hex_cnt_next = hex_cnt_reg;
        lit_sel_next = lit_sel_reg;
        lit_pos_next = lit_pos_reg;
        do_fail      = 1'b0;
        do_idle      = 1'b0;
        do_numend    = 1'b0;
        hex_val      = hex_value(in_byte);
        pos_inc      = lit_pos_reg + 3'd1;
        ir           = idle_step(in_byte);

        case (mode_reg)
            MODE_STR:
            begin
                if (in_byte == "\"")
                begin
                    run       = push(run, EV_STREND, 8'h00);
                    mode_next = MODE_IDLE;
                end
                else if (in_byte < CTRL_LIMIT)
                    do_fail = 1'b1;
                else if (in_byte == "\\")
                    mode_next = MODE_ESC;
                else
                    run = push(run, EV_STRBYTE, in_byte);
            end
            MODE_ESC:
            begin
                mode_next = MODE_STR;
                case (in_byte)
                    "\"", "\\", "/": run = push(run, EV_STRBYTE, in_byte);
                    "b":             run = push(run, EV_STRBYTE, 8'h08);
                    "f":             run = push(run, EV_STRBYTE, 8'h0C);
                    "n":             run = push(run, EV_STRBYTE, 8'h0A);
                    "r":             run = push(run, EV_STRBYTE, 8'h0D);
                    "t":             run = push(run, EV_STRBYTE, 8'h09);
                    "u":
                    begin
                        hex_acc_next = 16'h0000;
                        hex_cnt_next = 3'd0;
                        mode_next    = MODE_HEX;
                    end
                    default:         do_fail = 1'b1;
                endcase
            end
            MODE_HEX:
            begin
                if (hex_val[4])
                    do_fail = 1'b1;
                else
                begin
                    hex_acc_next = {hex_acc_reg[11:0], hex_val[3:0]};
                    hex_cnt_next = hex_cnt_reg + 3'd1;
                    if (hex_cnt_next >= 3'd4)
                    begin
                        hex_cnt_next = 3'd0;
                        mode_next    = MODE_STR;
                        if (hex_acc_next <= UTF8_MAX1)
                            run = push(run, EV_STRBYTE, hex_acc_next[7:0]);
                        else if (hex_acc_next <= UTF8_MAX2)
                        begin
                            run = push(run, EV_STRBYTE,
                                       UTF8_LEAD2 | {3'b000, hex_acc_next[10:6]});
                            run = push(run, EV_STRBYTE,
                                       UTF8_CONT | {2'b00, hex_acc_next[5:0] & UTF8_MASK});
                        end
                        else
                        begin
                            run = push(run, EV_STRBYTE,
                                       UTF8_LEAD3 | {4'h0, hex_acc_next[15:12]});
                            run = push(run, EV_STRBYTE,
                                       UTF8_CONT | {2'b00, hex_acc_next[11:6]});
                            run = push(run, EV_STRBYTE,
                                       UTF8_CONT | {2'b00, hex_acc_next[5:0] & UTF8_MASK});
                        end
                    end
                end
            end
            MODE_LIT:
            begin
                if (lit_pos_reg >= lit_len(lit_sel_reg) ||
                    in_byte != lit_char(lit_sel_reg, lit_pos_reg))
                    do_fail = 1'b1;
                else
                begin
                    lit_pos_next = pos_inc;
                    if (pos_inc >= lit_len(lit_sel_reg))
                    begin
                        mode_next = MODE_IDLE;
                        case (lit_sel_reg)
                            LIT_TRUE:  run = push(run, EV_TRUE, 8'h00);
                            LIT_FALSE: run = push(run, EV_FALSE, 8'h00);
                            default:   run = push(run, EV_NULL, 8'h00);
                        endcase
                    end
                end
            end
            MODE_NSIGN, MODE_NFRAC0, MODE_NEXPS:
            begin
                case (in_byte) inside
                    ["0":"9"]:
                    begin
                        run       = push(run, EV_NUMBYTE, in_byte);
                        mode_next = (mode_reg == MODE_NFRAC0) ? MODE_NFRAC :
                                    (mode_reg == MODE_NEXPS)  ? MODE_NEXP  : MODE_NINT;
                    end
                    default: do_fail = 1'b1;
                endcase
            end
            MODE_NINT, MODE_NFRAC, MODE_NEXP:
            begin
                case (in_byte) inside
                    ["0":"9"]: run = push(run, EV_NUMBYTE, in_byte);
                    ".":
                    begin
                        if (mode_reg == MODE_NINT)
                        begin
                            run       = push(run, EV_NUMBYTE, in_byte);
                            mode_next = MODE_NFRAC0;
                        end
                        else
                        begin
                            do_numend = 1'b1;
                            do_idle   = 1'b1;
                        end
                    end
                    "e", "E":
                    begin
                        if (mode_reg != MODE_NEXP)
                        begin
                            run       = push(run, EV_NUMBYTE, in_byte);
                            mode_next = MODE_NEXP0;
                        end
                        else
                        begin
                            do_numend = 1'b1;
                            do_idle   = 1'b1;
                        end
                    end
                    default:
                    begin
                        do_numend = 1'b1;
                        do_idle   = 1'b1;
                    end
                endcase
            end
            MODE_NEXP0:
            begin
                case (in_byte) inside
                    "+", "-":
                    begin
                        run       = push(run, EV_NUMBYTE, in_byte);
                        mode_next = MODE_NEXPS;
                    end
                    ["0":"9"]:
                    begin
                        run       = push(run, EV_NUMBYTE, in_byte);
                        mode_next = MODE_NEXP;
                    end
                    default: do_fail = 1'b1;
                endcase
            end
            MODE_ERR:
            begin
                if (in_byte == 8'h00)
                begin
                    run       = push(run, EV_END, 8'h00);
                    mode_next = MODE_IDLE;
                end
            end
            default:
                do_idle = 1'b1;
        endcase

        // A number that ends hands its terminating byte to the idle handling.
        if (do_idle)
        begin
            if (do_numend)
                run = push(run, EV_NUMEND, 8'h00);
            mode_next = ir.mode;
            if (ir.set_lit)
            begin
                lit_sel_next = ir.sel;
                lit_pos_next = 3'd0;
            end
            if (ir.emit)
                run = push(run, ir.kind, ir.ev_byte);
        end

        if (do_fail)
        begin
            run = push(run, EV_ERROR, 8'h00);
            if (in_byte == 8'h00)
            begin
                run       = push(run, EV_END, 8'h00);
                mode_next = MODE_IDLE;
            end
            else
                mode_next = MODE_ERR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            hex_acc_reg <= 16'h0000;
            hex_cnt_reg <= 3'd0;
            lit_sel_reg <= 2'd0;
            lit_pos_reg <= 3'd0;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            hex_acc_reg <= hex_acc_next;
            hex_cnt_reg <= hex_cnt_next;
            lit_sel_reg <= lit_sel_next;
            lit_pos_reg <= lit_pos_next;
        end
    end

endmodule

// ----- rtl/json_tok_run_buf.sv -----
// ----------------------------------------------------------------------------
// json_tok_run_buf
// Result register: holds one run of events and hands them out one per beat.
// ----------------------------------------------------------------------------
module json_tok_run_buf
    import json_tok_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  run_t                  run,
    output logic                  free,
    json_tok_out_if.source        events
);

    event_t [MAX_EVENTS-1:0] ev_reg;
    logic [1:0]              count_reg;
    logic [1:0]              idx_reg;
    logic                    fire;
    logic                    last;
    event_t                  cur;

    assign cur                = ev_reg[idx_reg];
    assign last               = (idx_reg == count_reg - 2'd1);
    assign fire               = events.valid && events.ready;
    assign free               = (count_reg == 2'd0) || (fire && last);

    assign events.valid       = (count_reg != 2'd0);
    assign events.event_kind  = cur.kind;
    assign events.event_byte  = cur.ev_byte;
    assign events.last_of_run = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            count_reg <= run.count;
            idx_reg   <= 2'd0;
        end
        else if (fire && last)
            count_reg <= 2'd0;
        else if (fire)
            idx_reg <= idx_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            ev_reg <= run.ev;
    end

endmodule

// ----- rtl/json_tok_checker.sv -----
// ----------------------------------------------------------------------------
// json_tok_checker
// Port-level checks on the event channel of the tokenizer, bound to the core.
// ----------------------------------------------------------------------------
module json_tok_port_checks
    import json_tok_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] event_kind,
    input logic [7:0] event_byte,
    input logic       last_of_run
);

    // A stalled event stays on the channel unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind) &&
                                   $stable(event_byte) && $stable(last_of_run))
    else $error("event changed while stalled");

    // Only string and number bytes carry a data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_STRBYTE && event_kind != EV_NUMBYTE
        |-> event_byte == 8'h00)
    else $error("nonzero byte on a token without data");

    // Only string bytes, number ends and errors can be followed in the same run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_STRBYTE && event_kind != EV_NUMEND &&
        event_kind != EV_ERROR |-> last_of_run)
    else $error("event that must end a run is not marked last");

    // No event code beyond the literal codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_kind <= EV_NULL)
    else $error("unknown event code");

endmodule

bind json_byte_tokenizer_core json_tok_port_checks u_json_tok_port_checks (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (tokens.valid),
    .out_ready   (tokens.ready),
    .event_kind  (tokens.event_kind),
    .event_byte  (tokens.event_byte),
    .last_of_run (tokens.last_of_run)
);

// ----- tb/json_tok_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_tok_checker
// Watches the text and event channels, lexes each accepted text byte on its
// own and compares every event beat with the oldest predicted event.
// ----------------------------------------------------------------------------
module json_tok_checker
    import json_tok_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    json_tok_in_if text,
    json_tok_out_if tokens,
    output int     fail_count,
    output int     pending
);

    typedef struct packed {
        ev_kind_t   kind;
        logic [7:0] ev_byte;
        logic       last;
    } token_t;

    token_t      token_q[$];   // predicted events, oldest first
    token_t      run_q[$];     // events of the byte being lexed
    token_t      want;
    lexer_mode_t mode;
    logic [15:0] hex_acc;
    logic [2:0]  hex_cnt;
    logic [1:0]  lit_sel;
    logic [2:0]  lit_pos;
    int          errs;
    int          shown;

    function automatic void add_event(ev_kind_t kind, logic [7:0] b);
        token_t t;
        if (run_q.size() < MAX_EVENTS)
        begin
            t.kind    = kind;
            t.ev_byte = b;
            t.last    = 1'b0;
            run_q.insert(run_q.size(), t);
        end
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    // A violation gives one error; a terminating zero also closes the document.
    function automatic void raise_error(logic [7:0] b);
        add_event(EV_ERROR, 8'h00);
        if (b == 8'h00)
        begin
            add_event(EV_END, 8'h00);
            mode = MODE_IDLE;
        end
        else
            mode = MODE_ERR;
    endfunction

    function automatic logic [7:0] literal_tail(logic [1:0] sel, logic [2:0] pos);
        case ({sel, pos})
            {LIT_TRUE, 3'd0}:  return "r";
            {LIT_TRUE, 3'd1}:  return "u";
            {LIT_TRUE, 3'd2}:  return "e";
            {LIT_FALSE, 3'd0}: return "a";
            {LIT_FALSE, 3'd1}: return "l";
            {LIT_FALSE, 3'd2}: return "s";
            {LIT_FALSE, 3'd3}: return "e";
            {LIT_NULL, 3'd0}:  return "u";
            {LIT_NULL, 3'd1}:  return "l";
            {LIT_NULL, 3'd2}:  return "l";
            default:           return 8'h00;
        endcase
    endfunction

    // First byte of a token, or whitespace between tokens.
    function automatic void lex_between(logic [7:0] b);
        mode = MODE_IDLE;
        if (b == 8'h00)
            add_event(EV_END, 8'h00);
        else if (b > CTRL_LIMIT)
        begin
            case (b)
                "{":  add_event(EV_LBRACE, 8'h00);
                "}":  add_event(EV_RBRACE, 8'h00);
                "[":  add_event(EV_LBRACKET, 8'h00);
                "]":  add_event(EV_RBRACKET, 8'h00);
                ":":  add_event(EV_COLON, 8'h00);
                ",":  add_event(EV_COMMA, 8'h00);
                "\"": mode = MODE_STR;
                "t", "f", "n":
                begin
                    lit_sel = (b == "t") ? LIT_TRUE : ((b == "f") ? LIT_FALSE : LIT_NULL);
                    lit_pos = 3'd0;
                    mode    = MODE_LIT;
                end
                "-":
                begin
                    add_event(EV_NUMBYTE, b);
                    mode = MODE_NSIGN;
                end
                default:
                begin
                    if (is_digit(b))
                    begin
                        add_event(EV_NUMBYTE, b);
                        mode = MODE_NINT;
                    end
                    else
                        raise_error(b);
                end
            endcase
        end
    endfunction

    function automatic void end_number(logic [7:0] b);
        add_event(EV_NUMEND, 8'h00);
        lex_between(b);
    endfunction

    function automatic void lex_byte(logic [7:0] b);
        logic [3:0]  nib;
        logic        nib_ok;
        logic [15:0] cp;
        logic [2:0]  len;
        run_q.delete();
        case (mode)
            MODE_STR:
            begin
                if (b == "\"")
                begin
                    add_event(EV_STREND, 8'h00);
                    mode = MODE_IDLE;
                end
                else if (b < CTRL_LIMIT)
                    raise_error(b);
                else if (b == "\\")
                    mode = MODE_ESC;
                else
                    add_event(EV_STRBYTE, b);
            end
            MODE_ESC:
            begin
                mode = MODE_STR;
                case (b)
                    "\"", "\\", "/": add_event(EV_STRBYTE, b);
                    "b": add_event(EV_STRBYTE, 8'h08);
                    "f": add_event(EV_STRBYTE, 8'h0C);
                    "n": add_event(EV_STRBYTE, 8'h0A);
                    "r": add_event(EV_STRBYTE, 8'h0D);
                    "t": add_event(EV_STRBYTE, 8'h09);
                    "u":
                    begin
                        hex_acc = 16'h0000;
                        hex_cnt = 3'd0;
                        mode    = MODE_HEX;
                    end
                    default: raise_error(b);
                endcase
            end
            MODE_HEX:
            begin
                nib_ok = 1'b1;
                nib    = 4'h0;
                if (b >= "0" && b <= "9")
                    nib = 4'(b - "0");
                else if (b >= "a" && b <= "f")
                    nib = 4'(b - "a" + 8'd10);
                else if (b >= "A" && b <= "F")
                    nib = 4'(b - "A" + 8'd10);
                else
                    nib_ok = 1'b0;
                if (!nib_ok)
                    raise_error(b);
                else
                begin
                    hex_acc = {hex_acc[11:0], nib};
                    hex_cnt = hex_cnt + 3'd1;
                    if (hex_cnt >= 3'd4)
                    begin
                        // Code point to UTF-8, one to three bytes, no surrogate pairing.
                        cp = hex_acc;
                        if (cp <= UTF8_MAX1)
                            add_event(EV_STRBYTE, cp[7:0]);
                        else if (cp <= UTF8_MAX2)
                        begin
                            add_event(EV_STRBYTE, UTF8_LEAD2 | {3'b000, cp[10:6]});
                            add_event(EV_STRBYTE, UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK});
                        end
                        else
                        begin
                            add_event(EV_STRBYTE, UTF8_LEAD3 | {4'h0, cp[15:12]});
                            add_event(EV_STRBYTE, UTF8_CONT | {2'b00, cp[11:6] & UTF8_MASK});
                            add_event(EV_STRBYTE, UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK});
                        end
                        hex_cnt = 3'd0;
                        mode    = MODE_STR;
                    end
                end
            end
            MODE_LIT:
            begin
                len = (lit_sel == LIT_FALSE) ? 3'd4 : 3'd3;
                if (lit_pos >= len || b != literal_tail(lit_sel, lit_pos))
                    raise_error(b);
                else
                begin
                    lit_pos = lit_pos + 3'd1;
                    if (lit_pos >= len)
                    begin
                        case (lit_sel)
                            LIT_TRUE:  add_event(EV_TRUE, 8'h00);
                            LIT_FALSE: add_event(EV_FALSE, 8'h00);
                            default:   add_event(EV_NULL, 8'h00);
                        endcase
                        mode = MODE_IDLE;
                    end
                end
            end
            MODE_NSIGN, MODE_NFRAC0, MODE_NEXPS:
            begin
                if (is_digit(b))
                begin
                    add_event(EV_NUMBYTE, b);
                    mode = (mode == MODE_NFRAC0) ? MODE_NFRAC :
                           ((mode == MODE_NEXPS) ? MODE_NEXP : MODE_NINT);
                end
                else
                    raise_error(b);
            end
            MODE_NINT:
            begin
                if (is_digit(b))
                    add_event(EV_NUMBYTE, b);
                else if (b == ".")
                begin
                    add_event(EV_NUMBYTE, b);
                    mode = MODE_NFRAC0;
                end
                else if (b == "e" || b == "E")
                begin
                    add_event(EV_NUMBYTE, b);
                    mode = MODE_NEXP0;
                end
                else
                    end_number(b);
            end
            MODE_NFRAC:
            begin
                if (is_digit(b))
                    add_event(EV_NUMBYTE, b);
                else if (b == "e" || b == "E")
                begin
                    add_event(EV_NUMBYTE, b);
                    mode = MODE_NEXP0;
                end
                else
                    end_number(b);
            end
            MODE_NEXP0:
            begin
                if (b == "+" || b == "-")
                begin
                    add_event(EV_NUMBYTE, b);
                    mode = MODE_NEXPS;
                end
                else if (is_digit(b))
                begin
                    add_event(EV_NUMBYTE, b);
                    mode = MODE_NEXP;
                end
                else
                    raise_error(b);
            end
            MODE_NEXP:
            begin
                if (is_digit(b))
                    add_event(EV_NUMBYTE, b);
                else
                    end_number(b);
            end
            MODE_ERR:
            begin
                if (b == 8'h00)
                begin
                    add_event(EV_END, 8'h00);
                    mode = MODE_IDLE;
                end
            end
            default: lex_between(b);
        endcase
        if (run_q.size() > 0)
            run_q[run_q.size() - 1].last = 1'b1;
        foreach (run_q[i])
            token_q.insert(token_q.size(), run_q[i]);
    endfunction

    function automatic void report(string what, int exp_val, int got_val);
        errs++;
        if (shown < 40)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, got_val);
        shown++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode    = MODE_IDLE;
            hex_acc = 16'h0000;
            hex_cnt = 3'd0;
            lit_sel = 2'd0;
            lit_pos = 3'd0;
            errs    = 0;
            shown   = 0;
            token_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (text.valid && text.ready)
                lex_byte(text.in_byte);
            if (tokens.valid && tokens.ready)
            begin
                if (token_q.size() == 0)
                begin
                    errs++;
                    if (shown < 40)
                        $display("%0t: unexpected event, expected none, got kind %0d byte 0x%02h",
                                 $time, tokens.event_kind, tokens.event_byte);
                    shown++;
                end
                else
                begin
                    want = token_q.pop_front();
                    if (tokens.event_kind !== want.kind)
                        report("event_kind", want.kind, tokens.event_kind);
                    if (tokens.event_byte !== want.ev_byte)
                        report("event_byte", want.ev_byte, tokens.event_byte);
                    if (tokens.last_of_run !== want.last)
                        report("last_of_run", want.last, tokens.last_of_run);
                end
            end
            fail_count <= errs;
            pending    <= token_q.size();
        end
    end

endmodule

// ----- tb/tb_json_byte_tokenizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_byte_tokenizer_core
// Streams JSON text through the tokenizer and judges its event stream.
// ----------------------------------------------------------------------------
// A short directed prologue exercises the main token shapes and the error
// paths. After it, random documents are built from well-formed tokens with
// random content, with a few cut short or disturbed by noise bytes. The
// checker module beside the block predicts and compares every event beat;
// this top only makes stimulus, random back-pressure and the verdict.
// ----------------------------------------------------------------------------
module tb_json_byte_tokenizer_core;

    localparam int TARGET_BYTES = 480;
    localparam int LIMIT_CYCLES = 500000;
    localparam int DRAIN_CYCLES = 16;

    logic       clk;
    logic       rst_n;
    logic       quiet = 1'b0;  // when set, neither side idles
    int         fail_count;
    int         pending;
    int         ready_hold = 0;
    int         ready_pick;
    int         cycle_count = 0;
    int         sent = 0;
    logic [7:0] doc_q[$];      // bytes of the document being built

    json_tok_in_if  text_if();
    json_tok_out_if tokens_if();

    json_byte_tokenizer_core u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .tokens (tokens_if)
    );

    json_tok_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text_if),
        .tokens     (tokens_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Watchdog: the run must finish well inside this many cycles.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("[json_byte_tokenizer_core] ERROR");
            $finish;
        end
    end

    // Event receiver back-pressure. Each ready level is held for a random
    // number of cycles; most holds are short, a few stalls are long, and
    // quiet stretches keep ready high throughout.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tokens_if.ready <= 1'b0;
            ready_hold      <= 0;
        end
        else if (quiet)
        begin
            tokens_if.ready <= 1'b1;
            ready_hold      <= 0;
        end
        else if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 55)
            begin
                tokens_if.ready <= 1'b1;
                ready_hold      <= $urandom_range(0, 4);
            end
            else if (ready_pick < 93)
            begin
                tokens_if.ready <= 1'b0;
                ready_hold      <= $urandom_range(0, 2);
            end
            else
            begin
                tokens_if.ready <= 1'b0;
                ready_hold      <= $urandom_range(8, 30);
            end
        end
    end

    // Idle cycles the sender leaves before a beat.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 25);
    endfunction

    // Offers one byte and returns at the edge where the beat is taken.
    // Valid is only lowered when a gap is actually inserted, so it never
    // gets two assignments in one time step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            text_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_if.valid   <= 1'b1;
        text_if.in_byte <= b;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_doc();
        while (doc_q.size() > 0)
            send_byte(doc_q.pop_front());
    endtask

    // Appends one byte to the document being built.
    task automatic put_byte(input logic [7:0] b);
        doc_q.insert(doc_q.size(), b);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10)
            return 8'h30 + nib;
        else
            return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    // Whitespace between tokens: mostly spaces, sometimes any byte 1..32.
    task automatic add_space();
        int n;
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            if ($urandom_range(0, 9) < 7)
                put_byte(8'h20);
            else
                put_byte(8'($urandom_range(1, 32)));
        end
    endtask

    task automatic add_punct();
        string p;
        p = "{}[]:,";
        put_byte(p[$urandom_range(0, 5)]);
    endtask

    task automatic add_literal();
        case ($urandom_range(0, 2))
            0:       add_text("true");
            1:       add_text("false");
            default: add_text("null");
        endcase
    endtask

    // Optional sign, integer digits, optional fraction, optional exponent.
    task automatic add_number();
        if ($urandom_range(0, 2) == 0)
            put_byte("-");
        repeat ($urandom_range(1, 3))
            put_byte(8'(8'h30 + $urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0)
        begin
            put_byte(".");
            repeat ($urandom_range(1, 3))
                put_byte(8'(8'h30 + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 2) == 0)
        begin
            put_byte($urandom_range(0, 1) ? "e" : "E");
            case ($urandom_range(0, 2))
                1:       put_byte("+");
                2:       put_byte("-");
                default: ;
            endcase
            repeat ($urandom_range(1, 2))
                put_byte(8'(8'h30 + $urandom_range(0, 9)));
        end
    endtask

    // A quoted string of plain bytes, simple escapes and \u escapes whose
    // code points span the one-, two- and three-byte UTF-8 forms. Rarely a
    // raw control byte or an arbitrary escape letter slips in.
    task automatic add_string();
        int          n;
        int          r;
        logic [7:0]  b;
        logic [15:0] cp;
        bit          upper;
        string       esc;
        esc = "\"\\/bfnrt";
        put_byte("\"");
        n = $urandom_range(0, 5);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                do
                    b = 8'($urandom_range(32, 255));
                while (b == "\"" || b == "\\");
                put_byte(b);
            end
            else if (r < 78)
            begin
                put_byte("\\");
                put_byte(esc[$urandom_range(0, 7)]);
            end
            else if (r < 96)
            begin
                case ($urandom_range(0, 2))
                    0:       cp = 16'($urandom_range(0, 16'h007F));
                    1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                endcase
                upper = 1'($urandom_range(0, 1));
                put_byte("\\");
                put_byte("u");
                put_byte(hex_char(cp[15:12], upper));
                put_byte(hex_char(cp[11:8], upper));
                put_byte(hex_char(cp[7:4], upper));
                put_byte(hex_char(cp[3:0], upper));
            end
            else if (r < 98)
                put_byte(8'($urandom_range(1, 31)));
            else
            begin
                put_byte("\\");
                put_byte(8'($urandom_range(8'h61, 8'h7A)));
            end
        end
        put_byte("\"");
    endtask

    // One document: a handful of tokens and a terminating zero. A few
    // documents are broken, either by cutting the last token short or by
    // noise bytes; those end soon after, so little of the text is ignored.
    task automatic build_doc();
        int n;
        int mark;
        int cut;
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            if ($urandom_range(0, 1))
                add_space();
            mark = doc_q.size();
            case ($urandom_range(0, 4))
                0, 4:    add_punct();
                1:       add_string();
                2:       add_number();
                default: add_literal();
            endcase
            if ($urandom_range(0, 29) == 0 && doc_q.size() - mark > 1)
            begin
                cut = $urandom_range(1, doc_q.size() - mark - 1);
                repeat (cut)
                    void'(doc_q.pop_back());
                break;
            end
            if ($urandom_range(0, 29) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    put_byte(8'($urandom_range(0, 255)));
                break;
            end
        end
        if ($urandom_range(0, 2) == 0)
            add_space();
        put_byte(8'h00);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        text_if.valid   = 1'b0;
        text_if.in_byte = 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed prologue. An object whose key is a three-byte \u escape
        // and whose value is a full number closed by a brace, so one byte
        // yields both the number end and the brace. Then a lone minus cut
        // off by the terminator, which yields an error and an end. Last, a
        // byte that cannot start a token, a byte ignored after the error,
        // and the terminator that brings the lexer back.
        add_text("{\"\\u20AC\":-0.5e+7}");
        put_byte(8'h00);
        put_byte("-");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte("x");
        put_byte(8'h00);
        send_doc();

        // Random documents, with quiet stretches where nobody idles.
        while (sent < TARGET_BYTES)
        begin
            quiet <= ($urandom_range(0, 5) == 0);
            build_doc();
            send_doc();
        end
        text_if.valid <= 1'b0;

        // Wait for every predicted event, then give stray events a chance
        // to show up before the verdict.
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[json_byte_tokenizer_core] OK");
        else
            $display("[json_byte_tokenizer_core] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/json_tok_pkg.sv
rtl/json_tok_in_if.sv
rtl/json_tok_out_if.sv
rtl/json_tok_lexer.sv
rtl/json_tok_run_buf.sv
rtl/json_byte_tokenizer_core.sv
rtl/json_tok_checker.sv
tb/json_tok_checker.sv
tb/tb_json_byte_tokenizer_core.sv
